// File: design/hsl_to_rgb_converter_core_defines.svh
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HSL2RGB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsl2rgb: property violated");

// Check that cons holds in the cycle after ante.
`define HSL2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsl2rgb: property violated");

`endif

// File: design/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 8;
    localparam int NUM_LANES = 3;

    // lane order
    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] saturation;
        logic [IN_W-1:0] lightness;
    } t_hsl_in;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb_out;

    // piece of the hue ramp a channel falls on
    typedef enum logic [1:0] {
        SEG_RISE   = 2'd0,
        SEG_TOP    = 2'd1,
        SEG_FALL   = 2'd2,
        SEG_BOTTOM = 2'd3
    } t_segment;

endpackage

// File: design/hsl_to_rgb_converter_core.sv
// Channel   Direction  Payload     Handshake
// request   in         t_hsl_in    i_in_valid / o_in_stall
// result    out        t_rgb_out   o_out_valid / i_out_stall
//
// One request per cycle unless a held result stalls the pipe; each result passes
// through five register stages: l*s multiply, upper/lower level and ramp factor,
// per-channel ramp multiply, level select, scale by 255 with clamp.
// Synchronous active-low reset clears only the stage valid bits.
// A stalled result freezes every stage; input stall rises only while the
// last stage holds a result that is stalled.
`include "hsl_to_rgb_converter_core_defines.svh"

module hsl_to_rgb_converter_core
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_hsl_in  i_in_data,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_rgb_out o_out_data,
    input  logic     i_out_stall
);

    localparam int F       = FRAC_BITS;
    localparam int NUM_STG = 5;
    localparam int V_W     = F + 3;
    localparam int C_W     = V_W + OUT_W - F;

    localparam longint ONE_L   = 64'd1 << F;
    localparam longint THIRD_L = (ONE_L + 1) / 3;
    localparam longint SIXTH_L = (ONE_L + 3) / 6;
    localparam longint TWO3_L  = (2 * ONE_L + 1) / 3;

    localparam logic [F-1:0] HALF_F  = F'(ONE_L >> 1);
    localparam logic [F-1:0] THIRD_F = F'(THIRD_L);
    localparam logic [F-1:0] SIXTH_F = F'(SIXTH_L);
    localparam logic [F-1:0] TWO3_F  = F'(TWO3_L);

    logic               w_adv;
    logic [NUM_STG:1]   r_vld;

    // stage 1
    logic [IN_W+F-1:0]  w_h_ext, w_s_ext, w_l_ext;
    logic [F-1:0]       w_h, w_s, w_l;
    logic [2*F-1:0]     n_s1_prod;
    logic [F-1:0]       n_s1_t [NUM_LANES];
    logic [F-1:0]       r_s1_l, r_s1_s, r_s1_ls;
    logic [F-1:0]       r_s1_t [NUM_LANES];

    // stage 2
    logic               w_low;
    logic [F:0]         n_s2_hi, n_s2_lo, n_s2_d;
    logic [F+2:0]       w_six  [NUM_LANES];
    logic [F-1:0]       w_diff [NUM_LANES];
    t_segment           n_s2_seg [NUM_LANES];
    logic [F:0]         n_s2_fac [NUM_LANES];
    logic [F:0]         r_s2_hi, r_s2_lo, r_s2_d;
    t_segment           r_s2_seg [NUM_LANES];
    logic [F:0]         r_s2_fac [NUM_LANES];

    // stage 3
    logic [2*F+1:0]     n_s3_prod [NUM_LANES];
    logic [F:0]         r_s3_hi, r_s3_lo;
    t_segment           r_s3_seg  [NUM_LANES];
    logic [F+1:0]       r_s3_part [NUM_LANES];

    // stage 4
    logic [V_W-1:0]     n_s4_v [NUM_LANES];
    logic [V_W-1:0]     r_s4_v [NUM_LANES];

    // stage 5
    logic [V_W+OUT_W-1:0] w_full [NUM_LANES];
    logic [C_W-1:0]       w_c    [NUM_LANES];
    logic [OUT_W-1:0]     n_s5_ch [NUM_LANES];
    t_rgb_out             r_s5_out;

    // advance the whole pipe unless a finished result is held back
    assign w_adv       = !r_vld[NUM_STG] || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[NUM_STG];
    assign o_out_data  = r_s5_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_STG-1:1], i_in_valid};
        end
    end

    // stage 1: bring fields to F fraction bits, l*s, channel hues
    always_comb begin
        w_h_ext = {i_in_data.hue, {F{1'b0}}};
        w_s_ext = {i_in_data.saturation, {F{1'b0}}};
        w_l_ext = {i_in_data.lightness, {F{1'b0}}};
        w_h = w_h_ext[IN_W+F-1:IN_W];
        w_s = w_s_ext[IN_W+F-1:IN_W];
        w_l = w_l_ext[IN_W+F-1:IN_W];
        n_s1_prod = w_l * w_s;
        // wrap is free: sums are taken modulo one
        n_s1_t[LANE_R] = w_h + THIRD_F;
        n_s1_t[LANE_G] = w_h;
        n_s1_t[LANE_B] = w_h - THIRD_F;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_l  <= w_l;
            r_s1_s  <= w_s;
            r_s1_ls <= n_s1_prod[2*F-1:F];
            r_s1_t  <= n_s1_t;
        end
    end

    // stage 2: upper and lower level, ramp segment and slope factor
    always_comb begin
        w_low = r_s1_l < HALF_F;
        if (w_low) begin
            n_s2_hi = {1'b0, r_s1_l} + {1'b0, r_s1_ls};
            n_s2_d  = {r_s1_ls, 1'b0};
        end else begin
            n_s2_hi = {1'b0, r_s1_l} + {1'b0, r_s1_s} - {1'b0, r_s1_ls};
            n_s2_d  = {r_s1_s - r_s1_ls, 1'b0};
        end
        n_s2_lo = {r_s1_l, 1'b0} - n_s2_hi;
        for (int k = 0; k < NUM_LANES; k++) begin
            w_diff[k]   = TWO3_F - r_s1_t[k];
            w_six[k]    = '0;
            n_s2_seg[k] = SEG_BOTTOM;
            n_s2_fac[k] = '0;
            if (r_s1_t[k] < SIXTH_F) begin
                w_six[k]    = (F+3)'({r_s1_t[k], 2'b00}) + (F+3)'({r_s1_t[k], 1'b0});
                n_s2_seg[k] = SEG_RISE;
                n_s2_fac[k] = w_six[k][F:0];
            end else if (r_s1_t[k] < HALF_F) begin
                n_s2_seg[k] = SEG_TOP;
            end else if (r_s1_t[k] < TWO3_F) begin
                w_six[k]    = (F+3)'({w_diff[k], 2'b00}) + (F+3)'({w_diff[k], 1'b0});
                n_s2_seg[k] = SEG_FALL;
                n_s2_fac[k] = w_six[k][F:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_hi  <= n_s2_hi;
            r_s2_lo  <= n_s2_lo;
            r_s2_d   <= n_s2_d;
            r_s2_seg <= n_s2_seg;
            r_s2_fac <= n_s2_fac;
        end
    end

    // stage 3: ramp product per channel
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_s3_prod[k] = r_s2_d * r_s2_fac[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_hi  <= r_s2_hi;
            r_s3_lo  <= r_s2_lo;
            r_s3_seg <= r_s2_seg;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_s3_part[k] <= n_s3_prod[k][2*F+1:F];
            end
        end
    end

    // stage 4: pick the channel level
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            case (r_s3_seg[k])
                SEG_RISE, SEG_FALL: begin
                    n_s4_v[k] = V_W'(r_s3_lo) + V_W'(r_s3_part[k]);
                end
                SEG_TOP: begin
                    n_s4_v[k] = V_W'(r_s3_hi);
                end
                default: begin
                    n_s4_v[k] = V_W'(r_s3_lo);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_v <= n_s4_v;
        end
    end

    // stage 5: scale by 255, clamp overshoot
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            w_full[k]  = {r_s4_v[k], {OUT_W{1'b0}}} - (V_W+OUT_W)'(r_s4_v[k]);
            w_c[k]     = w_full[k][V_W+OUT_W-1:F];
            n_s5_ch[k] = (w_c[k][C_W-1:OUT_W] != '0) ? {OUT_W{1'b1}} : w_c[k][OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_out.red   <= n_s5_ch[LANE_R];
            r_s5_out.green <= n_s5_ch[LANE_G];
            r_s5_out.blue  <= n_s5_ch[LANE_B];
        end
    end

    `HSL2RGB_ASSERT_SAME(a_stall_back, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `HSL2RGB_ASSERT_SAME(a_lo_le_hi, i_clk, i_rst_n, r_vld[2], r_s2_lo <= r_s2_hi)
    `HSL2RGB_ASSERT_NEXT(a_s4_to_out, i_clk, i_rst_n, r_vld[NUM_STG-1] && !o_in_stall, o_out_valid)

endmodule

// File: tb/tb_hsl_to_rgb_converter_core.sv
module tb_hsl_to_rgb_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    localparam int FRAC_BITS = 16;

    // fixed-point constants at the internal precision
    localparam logic [63:0] UNIT      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FRAC_MASK = UNIT - 64'd1;
    localparam logic [63:0] HALF_PT   = UNIT >> 1;
    localparam logic [63:0] THIRD_PT  = (UNIT + 64'd1) / 64'd3;
    localparam logic [63:0] SIXTH_PT  = (UNIT + 64'd3) / 64'd6;
    localparam logic [63:0] TWO3_PT   = (64'd2 * UNIT + 64'd1) / 64'd3;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_hsl_in  i_in_data   = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_rgb_out o_out_data;
    logic     i_out_stall = 1'b0;

    t_rgb_out expected_rgb[$];
    int       sender_idle_pct = 0;
    int       out_stall_pct   = 0;
    int       out_hold_len    = 0;
    int       error_count     = 0;
    int       sent_count      = 0;
    int       checked_count   = 0;

    hsl_to_rgb_converter_core #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] to_frac(input logic [15:0] x);
        logic [63:0] wide;
        wide = {48'd0, x};
        if (FRAC_BITS >= 16) begin
            return wide << (FRAC_BITS - 16);
        end
        return wide >> (16 - FRAC_BITS);
    endfunction

    function automatic logic [63:0] ramp_level(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [63:0] t);
        logic [63:0] span;
        t_segment    seg;
        span = hi - lo;
        if (t < SIXTH_PT) begin
            seg = SEG_RISE;
        end else if (t < HALF_PT) begin
            seg = SEG_TOP;
        end else if (t < TWO3_PT) begin
            seg = SEG_FALL;
        end else begin
            seg = SEG_BOTTOM;
        end
        case (seg)
            SEG_RISE: return lo + ((span * 64'd6 * t) >> FRAC_BITS);
            SEG_TOP:  return hi;
            SEG_FALL: return lo + ((span * (TWO3_PT - t) * 64'd6) >> FRAC_BITS);
            default:  return lo;
        endcase
    endfunction

    function automatic logic [7:0] scale_to_byte(input logic [63:0] v);
        logic [63:0] c;
        c = (v * 64'd255) >> FRAC_BITS;
        return (c > 64'd255) ? 8'd255 : c[7:0];
    endfunction

    function automatic t_rgb_out predict_rgb(input t_hsl_in req);
        logic [63:0] h, s, l, ls, hi, lo, r, g, b;
        t_rgb_out    rgb;
        h = to_frac(req.hue);
        s = to_frac(req.saturation);
        l = to_frac(req.lightness);
        if (s == 64'd0) begin
            r = l;
            g = l;
            b = l;
        end else begin
            ls = (l * s) >> FRAC_BITS;
            hi = (l < HALF_PT) ? (l + ls) : (l + s - ls);
            lo = 64'd2 * l - hi;
            r  = ramp_level(lo, hi, (h + THIRD_PT) & FRAC_MASK);
            g  = ramp_level(lo, hi, h);
            b  = ramp_level(lo, hi, (h + UNIT - THIRD_PT) & FRAC_MASK);
        end
        rgb.red   = scale_to_byte(r);
        rgb.green = scale_to_byte(g);
        rgb.blue  = scale_to_byte(b);
        return rgb;
    endfunction

    // ------------------------------------------------------- stimulus helpers

    // Mostly full-range values; some gray, some near the half-lightness split,
    // some hues near the ramp breakpoints and the wrap points.
    function automatic t_hsl_in random_request();
        t_hsl_in     req;
        logic [15:0] anchor;
        req = {16'($urandom), 16'($urandom), 16'($urandom)};
        case ($urandom_range(9))
            0: req.saturation = 16'd0;
            1: req.lightness  = 16'd32768 + 16'($urandom_range(8)) - 16'd4;
            2, 3: begin
                case ($urandom_range(5))
                    0: anchor = 16'd0;
                    1: anchor = 16'd10923;
                    2: anchor = 16'd21845;
                    3: anchor = 16'd32768;
                    4: anchor = 16'd43691;
                    default: anchor = 16'd65535;
                endcase
                req.hue = anchor + 16'($urandom_range(4)) - 16'd2;
            end
            default: ;
        endcase
        return req;
    endfunction

    task automatic send_request(input t_hsl_in req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_rgb.push_back(predict_rgb(req));
        sent_count++;
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_rgb.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------- receiver / check

    always @(posedge i_clk) begin
        if (out_hold_len > 0) begin
            i_out_stall <= 1'b1;
            out_hold_len--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rgb_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            checked_count++;
            if (expected_rgb.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result r=%0d g=%0d b=%0d", o_out_data.red,
                             o_out_data.green, o_out_data.blue);
                end
            end else begin
                want = expected_rgb.pop_front();
                if (o_out_data.red !== want.red || o_out_data.green !== want.green ||
                    o_out_data.blue !== want.blue) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue, o_out_data.red,
                                 o_out_data.green, o_out_data.blue);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------ tests

    task automatic test_corners();
        sender_idle_pct = 0;
        out_stall_pct   = 0;
        // hue, saturation, lightness
        send_request({16'd0,     16'd0,     16'd0});
        send_request({16'd65535, 16'd65535, 16'd65535});
        send_request({16'd4660,  16'd0,     16'd65535});   // gray, full lightness
        send_request({16'd43981, 16'd0,     16'd32768});   // gray, mid
        send_request({16'd0,     16'd1,     16'd32768});   // smallest saturation
        send_request({16'd0,     16'd65535, 16'd32767});   // just below half lightness
        send_request({16'd0,     16'd65535, 16'd32768});   // at half lightness
        send_request({16'd10922, 16'd65535, 16'd32768});
        send_request({16'd10923, 16'd65535, 16'd32768});
        send_request({16'd32767, 16'd65535, 16'd32768});
        send_request({16'd32768, 16'd65535, 16'd32768});
        send_request({16'd43690, 16'd65535, 16'd32768});
        send_request({16'd43691, 16'd65535, 16'd32768});   // red hue wraps to zero
        send_request({16'd21844, 16'd65535, 16'd32768});   // blue hue wraps up
        send_request({16'd21845, 16'd65535, 16'd32768});
        send_request({16'd65535, 16'd65535, 16'd32768});
        send_request({16'd0,     16'd65535, 16'd1});
        send_request({16'd0,     16'd65535, 16'd65535});
        send_request({16'd32768, 16'd65535, 16'd49152});   // constant rounding overshoot
        send_request({16'd43690, 16'd21845, 16'd21845});
        send_request({16'd21845, 16'd43690, 16'd43690});
        wait_for_drain();
    endtask

    task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        out_stall_pct   = stall_pct;
        repeat (count) send_request(random_request());
    endtask

    // Hold the output long enough for the pipe to fill and push back on input,
    // then pause the sender until everything has come out.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        out_stall_pct   = 0;
        out_hold_len    = 80;
        repeat (40) send_request(random_request());
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_random_mix(400, 0, 0);
        test_random_mix(400, 47, 0);
        test_backpressure();
        test_random_mix(400, 0, 47);
        test_random_mix(400, 37, 37);

        out_stall_pct = 0;
        wait_for_drain();
        repeat (20) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results: corners, hue wraps, gray,",
                 sent_count, checked_count);
        $display("four idle/stall mixes and one long output hold");
        if (error_count == 0 && expected_rgb.size() == 0) begin
            $display("tb_hsl_to_rgb_converter_core: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count, expected_rgb.size());
            $display("tb_hsl_to_rgb_converter_core: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_rgb.size());
        $display("tb_hsl_to_rgb_converter_core: FAIL");
        $finish;
    end

endmodule
